>>> sv/mttt_pkg.sv
// Shared command and status types for the tournament tree controller and datapath.
package mttt_pkg;

    localparam int ITEM_BITS  = 8;
    localparam int TIME_BITS  = 32;
    localparam int TDATA_BITS = 40;
    localparam int CALC_BITS  = 12;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic write_leaf;
        logic climb;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic at_top;
        logic in_range;
        logic out_free;
    } dp_sts_t;

endpackage

>>> sv/min_time_tournament_tree.sv
// Top level of the tournament tree that reports the item with the earliest event time.
// Each item on the s_ channel replaces one item's event time and returns, on the m_
// channel, the item that now holds the smallest time and that time. Times are unsigned
// fixed point with 16 fraction bits; equal times go to the lower leaf.
// After aresetn is released a clearing pass fills the node memory with "no event"
// keys; s_tready stays low during it.
// An item for a valid index takes one leaf write plus one match per tree level; an
// item that owns two leaves writes their shared parent and so has one match fewer.
// The node memory reads one sibling and writes one parent per cycle. An index beyond
// the item count leaves the tree as it is and returns the current root through the
// EMIT state once the output register is free.
// One item is in work at a time. The result sits in an output register, so the next
// item may be accepted while it waits; if the receiver stalls, a finished result is
// held until the register frees up and no further item is accepted meanwhile.
module min_time_tournament_tree #(
    parameter int NUM_ITEMS = 256,
    parameter int KEY_BITS  = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: item_index [7:0], new_key [39:8]
    input  logic [mttt_pkg::TDATA_BITS-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: winner_index [7:0], winner_key [39:8]
    output logic [mttt_pkg::TDATA_BITS-1:0] m_tdata
);
    import mttt_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    mttt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mttt_dpath #(
        .NUM_ITEMS (NUM_ITEMS),
        .KEY_BITS  (KEY_BITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> sv/mttt_ctrl.sv
// Controller state machine that sequences clearing, leaf writes, tree climbs and result output.
module mttt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mttt_pkg::dp_sts_t sts,
    output mttt_pkg::dp_cmd_t cmd
);
    import mttt_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_WRITE = 5'b00100,
        ST_CLIMB = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_range ? ST_WRITE : ST_EMIT;
                end
            end
            ST_WRITE: begin
                cmd.write_leaf = 1'b1;
                state_next     = ST_CLIMB;
            end
            ST_CLIMB: begin
                cmd.climb = 1'b1;
                if (sts.at_top) begin
                    if (sts.out_free) begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

>>> sv/mttt_dpath.sv
// Datapath with the node memory, the climbing match unit, the root copy and the output register.
module mttt_dpath #(
    parameter int NUM_ITEMS = 256,
    parameter int KEY_BITS  = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [mttt_pkg::TDATA_BITS-1:0] s_tdata,
    input  mttt_pkg::dp_cmd_t               cmd,
    output mttt_pkg::dp_sts_t               sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mttt_pkg::TDATA_BITS-1:0] m_tdata
);
    import mttt_pkg::*;

    localparam int LG     = $clog2(NUM_ITEMS);
    localparam int LEAVES = 2 ** LG;
    localparam int SINGLE = 2 * NUM_ITEMS - LEAVES;
    localparam int HW     = LG + 1;
    localparam int DEPTH  = 2 * LEAVES;
    localparam int IW     = LG;
    localparam int SW     = $clog2(LG + 1);

    logic [KEY_BITS-1:0] mem_key [DEPTH];
    logic [IW-1:0]       mem_win [DEPTH];

    logic [HW-1:0]       clr_h_reg;
    logic [SW-1:0]       clr_shift_reg;
    logic [HW-1:0]       h_reg;
    logic [KEY_BITS-1:0] cur_key_reg;
    logic [IW-1:0]       cur_win_reg;
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [IW-1:0]       rd_win_reg;
    logic [KEY_BITS-1:0] root_key_reg;
    logic [IW-1:0]       root_win_reg;
    logic                m_tvalid_reg;
    logic [TDATA_BITS-1:0] m_tdata_reg;

    logic [ITEM_BITS-1:0] s_item;
    logic [TIME_BITS-1:0] s_time;
    logic [CALC_BITS-1:0] item_ext;
    logic [CALC_BITS-1:0] start_ext;
    logic [HW-1:0]        clr_leftmost;
    logic [CALC_BITS-1:0] clr_leaf;
    logic [CALC_BITS-1:0] clr_owner;
    logic [HW-1:0]        parent_h;
    logic                 cur_is_left;
    logic [KEY_BITS-1:0]  left_key;
    logic [IW-1:0]        left_win;
    logic [KEY_BITS-1:0]  right_key;
    logic [IW-1:0]        right_win;
    logic [KEY_BITS-1:0]  parent_key;
    logic [IW-1:0]        parent_win;
    logic                 wr_en;
    logic [HW-1:0]        wr_addr;
    logic [KEY_BITS-1:0]  wr_key;
    logic [IW-1:0]        wr_win;
    logic                 rd_en;
    logic [HW-1:0]        rd_addr;
    logic [KEY_BITS-1:0]  out_key;
    logic [IW-1:0]        out_win;
    logic [63:0]          out_key_ext;
    logic [15:0]          out_win_ext;

    assign s_item = s_tdata[ITEM_BITS-1:0];
    assign s_time = s_tdata[ITEM_BITS +: TIME_BITS];

    // Single items start at their leaf; a paired item starts at the parent of its two leaves.
    assign item_ext  = CALC_BITS'(s_item);
    assign start_ext = (item_ext < CALC_BITS'(SINGLE)) ?
                       CALC_BITS'(LEAVES) + item_ext :
                       CALC_BITS'(LEAVES / 2) + item_ext - CALC_BITS'(SINGLE / 2);

    assign clr_leftmost = HW'(clr_h_reg << clr_shift_reg);
    assign clr_leaf     = CALC_BITS'(clr_leftmost[LG-1:0]);
    assign clr_owner    = (clr_leaf < CALC_BITS'(SINGLE)) ? clr_leaf :
                          CALC_BITS'(SINGLE) + ((clr_leaf - CALC_BITS'(SINGLE)) >> 1);

    assign parent_h    = h_reg >> 1;
    assign cur_is_left = ~h_reg[0];
    assign left_key    = cur_is_left ? cur_key_reg : rd_key_reg;
    assign left_win    = cur_is_left ? cur_win_reg : rd_win_reg;
    assign right_key   = cur_is_left ? rd_key_reg  : cur_key_reg;
    assign right_win   = cur_is_left ? rd_win_reg  : cur_win_reg;

    // The left child keeps the node on equal keys.
    assign parent_key = (right_key < left_key) ? right_key : left_key;
    assign parent_win = (right_key < left_key) ? right_win : left_win;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = clr_h_reg;
        wr_key  = '1;
        wr_win  = IW'(clr_owner);
        rd_en   = 1'b0;
        rd_addr = h_reg ^ HW'(1);
        if (cmd.clr_step) begin
            wr_en = 1'b1;
        end else if (cmd.write_leaf) begin
            wr_en   = 1'b1;
            wr_addr = h_reg;
            wr_key  = cur_key_reg;
            wr_win  = cur_win_reg;
            rd_en   = 1'b1;
        end else if (cmd.climb) begin
            wr_en   = 1'b1;
            wr_addr = parent_h;
            wr_key  = parent_key;
            wr_win  = parent_win;
            rd_en   = 1'b1;
            rd_addr = parent_h ^ HW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_key[wr_addr] <= wr_key;
            mem_win[wr_addr] <= wr_win;
        end
        if (rd_en) begin
            rd_key_reg <= mem_key[rd_addr];
            rd_win_reg <= mem_win[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_h_reg     <= HW'(1);
            clr_shift_reg <= SW'(LG);
        end else if (cmd.clr_step) begin
            clr_h_reg <= clr_h_reg + HW'(1);
            if ((clr_h_reg & (clr_h_reg + HW'(1))) == '0) begin
                clr_shift_reg <= clr_shift_reg - SW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            h_reg       <= HW'(start_ext);
            cur_key_reg <= KEY_BITS'(s_time);
            cur_win_reg <= IW'(s_item);
        end else if (cmd.climb) begin
            h_reg       <= parent_h;
            cur_key_reg <= parent_key;
            cur_win_reg <= parent_win;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step && clr_h_reg == HW'(1)) begin
            root_key_reg <= '1;
            root_win_reg <= IW'(clr_owner);
        end else if (cmd.climb && sts.at_top) begin
            root_key_reg <= parent_key;
            root_win_reg <= parent_win;
        end
    end

    assign out_key     = cmd.climb ? parent_key : root_key_reg;
    assign out_win     = cmd.climb ? parent_win : root_win_reg;
    assign out_key_ext = 64'(out_key);
    assign out_win_ext = 16'(out_win);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {out_key_ext[TIME_BITS-1:0], out_win_ext[ITEM_BITS-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign sts.clr_last = (clr_h_reg == HW'(DEPTH - 1));
    assign sts.at_top   = (parent_h == HW'(1));
    assign sts.in_range = (item_ext < CALC_BITS'(NUM_ITEMS));
    assign sts.out_free = ~m_tvalid_reg | m_tready;

    a_climb_below_root: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.climb |-> h_reg > HW'(1))
        else $error("climb issued at the root");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_match_minimum: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.climb |-> (parent_key <= cur_key_reg && parent_key <= rd_key_reg))
        else $error("match winner is not the smaller key");

    a_root_follows_top: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.climb && sts.at_top |=> root_key_reg == $past(parent_key))
        else $error("root copy missed the final match");

endmodule
